/* sv/i2c_master_transfer_engine_core_macros.svh */
// ----------------------------------------------------------------------------
// i2c_master_transfer_engine_core_macros: assertion helpers
// Same-cycle and next-cycle implication checks shared by the engine RTL.
// ----------------------------------------------------------------------------
// Each macro takes a label, the clock, the active-low reset and the two sides of
// the implication.
`ifndef I2C_MASTER_TRANSFER_ENGINE_CORE_MACROS_SVH
`define I2C_MASTER_TRANSFER_ENGINE_CORE_MACROS_SVH

// Same-cycle implication
`define I2CM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("i2cm same-cycle check failed");

// Next-cycle implication
`define I2CM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("i2cm next-cycle check failed");

`endif

/* sv/i2cm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_pkg: shared types and constants of the I2C master transfer engine
// Phase codes, request codes, register indexes and the structs passed
// between the top level and the per-tick step logic.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    // Request kinds carried in s_tuser
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_ADDR_W  = 3;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAP_TICKS     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BIT_TICKS     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SETTLE_TICKS  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_STRETCH_POLLS = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_INHIBIT       = 3'd4;

    localparam logic [7:0]  GAP_RESET    = 8'd3;
    localparam logic [7:0]  BIT_RESET    = 8'd5;
    localparam logic [15:0] SETTLE_RESET = 16'd170;
    localparam logic [9:0]  POLLS_RESET  = 10'd200;
    localparam logic [2:0]  TOP_BIT      = 3'd7;

    localparam int unsigned IN_DATA_W  = 32;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 24;

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST2, PH_ST3, PH_ST4, PH_WB_BEGIN, PH_WB_LOAD, PH_WB_BIT,
        PH_WB_HI, PH_WB_LO, PH_WB_END, PH_POLL_A, PH_POLL_R, PH_CK,
        PH_RB_BEGIN, PH_RB_HI, PH_RB_SMP, PH_RB_LO, PH_ACK_DRV, PH_ACK_HI,
        PH_ACK_LO, PH_REL_R, PH_STOP1, PH_STOP2, PH_STOP3, PH_SETTLE
    } phase_t;

    typedef struct packed {
        logic sda_en;
        logic sda_lvl;
        logic scl_en;
        logic scl_lvl;
    } pins_t;

    typedef struct packed {
        logic [7:0]  gap_ticks;
        logic [7:0]  bit_ticks;
        logic [15:0] settle_ticks;
        logic [9:0]  stretch_polls;
        logic        inhibit;
    } cfg_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] slave_byte;
        logic [7:0] byte_count;
        logic [7:0] write_data;
        logic       sda_in;
        logic       scl_in;
    } beat_t;

    typedef struct packed {
        phase_t      phase;
        logic [15:0] tick_timer;
        logic [9:0]  poll_count;
        logic [2:0]  bit_index;
        logic [7:0]  shift_byte;
        logic [7:0]  bytes_left;
        logic        is_read;
        pins_t       pins;
    } state_t;

    typedef struct packed {
        pins_t      pins;
        logic       busy_res;
        logic       byte_taken;
        logic       read_valid;
        logic [7:0] read_data;
        logic       ack_valid;
        logic       ack_low;
        logic       done_res;
        logic       refused;
    } res_t;

    localparam pins_t PINS_HIGH = '{sda_en: 1'b1, sda_lvl: 1'b1, scl_en: 1'b1, scl_lvl: 1'b1};

    localparam state_t STATE_RESET = '{
        phase:      PH_IDLE,
        tick_timer: 16'd0,
        poll_count: 10'd0,
        bit_index:  TOP_BIT,
        shift_byte: 8'd0,
        bytes_left: 8'd0,
        is_read:    1'b0,
        pins:       PINS_HIGH
    };

    localparam cfg_t CFG_RESET = '{
        gap_ticks:     GAP_RESET,
        bit_ticks:     BIT_RESET,
        settle_ticks:  SETTLE_RESET,
        stretch_polls: POLLS_RESET,
        inhibit:       1'b0
    };

    function automatic pins_t drive_scl(input pins_t p, input logic lvl);
        pins_t r;
        r = p;
        r.scl_en  = 1'b1;
        r.scl_lvl = lvl;
        return r;
    endfunction

    function automatic pins_t drive_sda(input pins_t p, input logic lvl);
        pins_t r;
        r = p;
        r.sda_en  = 1'b1;
        r.sda_lvl = lvl;
        return r;
    endfunction

    function automatic pins_t release_scl(input pins_t p);
        pins_t r;
        r = p;
        r.scl_en  = 1'b0;
        r.scl_lvl = 1'b1;
        return r;
    endfunction

    function automatic pins_t release_sda(input pins_t p);
        pins_t r;
        r = p;
        r.sda_en  = 1'b0;
        r.sda_lvl = 1'b1;
        return r;
    endfunction

endpackage

/* sv/i2c_master_transfer_engine_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_transfer_engine_core: tick-driven I2C master sequencer
// Runs start, address, clock-stretch wait, ack, data bytes and stop, one
// timing tick per input beat, with a result beat for every tick.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one beat per timing tick. s_tuser carries the request kind
//   (tick only, read, write); s_tdata carries the address byte, byte count,
//   next write byte and the sampled SDA/SCL levels.
//   m_ channel: one beat per accepted tick with the pin drive after that tick
//   and the event flags (byte_taken, read_valid, ack, done, refused).
//   cfg port: write-only registers, taken at any edge with cfg_wr_en high;
//   write them only while no transfer runs.
// Timing: a result beat appears in the cycle after its tick is accepted;
//   one tick is accepted every cycle unless a result is held. The only storage
//   in the path is the sequencer state register and the result register.
// Reset: sequencer goes idle with both lines driven high, registers take
//   their defaults, the result register empties.
// Stall: while a result waits and m_tready is low, s_tready drops and the
//   sequencer holds; it resumes the cycle the result is taken.
module i2c_master_transfer_engine_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata, lowest bit up: slave_byte[7:0], byte_count[7:0], write_data[7:0],
    // sda_in, scl_in, zero fill
    input  logic [i2cm_pkg::IN_DATA_W-1:0]      s_tdata,
    // s_tuser: req_type[1:0]
    input  logic [i2cm_pkg::IN_USER_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata, lowest bit up: scl_level, scl_enable, sda_level, sda_enable,
    // busy_res, byte_taken, read_valid, read_data[7:0], ack_valid, ack_low,
    // done_res, refused, zero fill
    output logic [i2cm_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [i2cm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import i2cm_pkg::*;

    cfg_t   cfg_reg;
    state_t state_reg;
    state_t state_next;
    beat_t  beat;
    res_t   res_next;
    res_t   res_reg;
    logic   m_tvalid_reg;
    logic   s_accept;

    // Unpack the tick beat
    assign beat.req_type   = s_tuser;
    assign beat.slave_byte = s_tdata[7:0];
    assign beat.byte_count = s_tdata[15:8];
    assign beat.write_data = s_tdata[23:16];
    assign beat.sda_in     = s_tdata[24];
    assign beat.scl_in     = s_tdata[25];

    // Take a tick whenever the result slot is free or being drained
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // Configuration registers: plain writes, unused indexes dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_GAP_TICKS:     cfg_reg.gap_ticks     <= cfg_wdata[7:0];
                CFG_BIT_TICKS:     cfg_reg.bit_ticks     <= cfg_wdata[7:0];
                CFG_SETTLE_TICKS:  cfg_reg.settle_ticks  <= cfg_wdata[15:0];
                CFG_STRETCH_POLLS: cfg_reg.stretch_polls <= cfg_wdata[9:0];
                CFG_INHIBIT:       cfg_reg.inhibit       <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    i2cm_step u_step (
        .cfg_i   (cfg_reg),
        .state_i (state_reg),
        .beat_i  (beat),
        .state_o (state_next),
        .res_o   (res_next)
    );

    // Advance the sequencer only on an accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Result payload: load on accept, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, res_reg.refused, res_reg.done_res, res_reg.ack_low,
                       res_reg.ack_valid, res_reg.read_data, res_reg.read_valid,
                       res_reg.byte_taken, res_reg.busy_res, res_reg.pins.sda_en,
                       res_reg.pins.sda_lvl, res_reg.pins.scl_en, res_reg.pins.scl_lvl};

`include "i2c_master_transfer_engine_core_macros.svh"

    // A held result must block new ticks
    `I2CM_ASSERT_NOW(a_stall_blocks, aclk, aresetn, m_tvalid_reg && !m_tready, !s_tready)
    // Every accepted tick yields a result beat next cycle
    `I2CM_ASSERT_NEXT(a_accept_result, aclk, aresetn, s_accept, m_tvalid_reg)
    // Idle is only reached with the delay counter drained
    `I2CM_ASSERT_NOW(a_idle_timer, aclk, aresetn, state_reg.phase == PH_IDLE,
                     state_reg.tick_timer == 16'd0)
    // The settle-done beat already reports not busy
    `I2CM_ASSERT_NOW(a_done_not_busy, aclk, aresetn, m_tvalid_reg && res_reg.done_res,
                     !res_reg.busy_res)

endmodule

/* sv/i2cm_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_step: per-tick transition of the transfer sequencer
// Combinational next state and result flags for one tick beat.
// ----------------------------------------------------------------------------
module i2cm_step (
    input  i2cm_pkg::cfg_t   cfg_i,
    input  i2cm_pkg::state_t state_i,
    input  i2cm_pkg::beat_t  beat_i,
    output i2cm_pkg::state_t state_o,
    output i2cm_pkg::res_t   res_o
);
    import i2cm_pkg::*;

    // End of a stretch wait: drive SCL high and move on
    function automatic state_t finish_wait(input state_t s, input cfg_t c,
                                           input logic after_read);
        state_t r;
        r = s;
        r.pins = drive_scl(s.pins, 1'b1);
        if (!after_read) begin
            r.tick_timer = {8'd0, c.gap_ticks};
            r.phase      = PH_CK;
        end else begin
            r.tick_timer = 16'd0;
            r.phase      = (s.bytes_left != 8'd0) ? PH_RB_BEGIN : PH_STOP1;
        end
        return r;
    endfunction

    // Release SCL and start polling, or finish at once with no poll budget
    function automatic state_t start_wait(input state_t s, input cfg_t c,
                                          input logic after_read);
        state_t r;
        r = s;
        if (c.stretch_polls == 10'd0) begin
            r = finish_wait(s, c, after_read);
        end else begin
            r.pins       = release_scl(s.pins);
            r.poll_count = 10'd0;
            r.tick_timer = {8'd0, c.bit_ticks};
            r.phase      = after_read ? PH_POLL_R : PH_POLL_A;
        end
        return r;
    endfunction

    function automatic state_t begin_wbyte(input state_t s, input cfg_t c);
        state_t r;
        r = s;
        r.pins.sda_en = 1'b1;
        r.bit_index   = TOP_BIT;
        r.tick_timer  = {8'd0, c.bit_ticks} + {8'd0, c.gap_ticks};
        r.phase       = PH_WB_BIT;
        return r;
    endfunction

    logic        is_req;
    logic [9:0]  poll_inc;
    logic [7:0]  smp_byte;
    state_t      s;
    logic [15:0] gap16;
    logic [15:0] bit16;

    assign gap16    = {8'd0, cfg_i.gap_ticks};
    assign bit16    = {8'd0, cfg_i.bit_ticks};
    assign poll_inc = state_i.poll_count + 10'd1;

    always_comb begin
        smp_byte = state_i.shift_byte;
        smp_byte[state_i.bit_index] = state_i.shift_byte[state_i.bit_index] | beat_i.sda_in;
    end

    always_comb begin
        is_req = beat_i.req_type inside {REQ_READ, REQ_WRITE};
        s      = state_i;
        res_o  = '0;
        res_o.refused = is_req && cfg_i.inhibit;

        if (state_i.phase != PH_IDLE && state_i.tick_timer != 16'd0) begin
            s.tick_timer = state_i.tick_timer - 16'd1;
        end else begin
            case (state_i.phase)
                PH_IDLE: begin
                    if (is_req && !cfg_i.inhibit) begin
                        s.is_read     = (beat_i.req_type == REQ_READ);
                        s.shift_byte  = beat_i.slave_byte;
                        s.bytes_left  = beat_i.byte_count;
                        s.pins        = drive_sda(state_i.pins, 1'b1);
                        s.pins.scl_en = 1'b1;
                        s.tick_timer  = gap16;
                        s.phase       = PH_ST2;
                    end
                end
                PH_ST2: begin
                    s.pins = drive_scl(state_i.pins, 1'b1);
                    s.tick_timer = bit16;
                    s.phase = PH_ST3;
                end
                PH_ST3: begin
                    s.pins = drive_sda(state_i.pins, 1'b0);
                    s.tick_timer = bit16;
                    s.phase = PH_ST4;
                end
                PH_ST4: begin
                    s.pins = drive_scl(state_i.pins, 1'b0);
                    s.tick_timer = gap16;
                    s.phase = PH_WB_BEGIN;
                end
                PH_WB_LOAD: begin
                    s.shift_byte = beat_i.write_data;
                    s.bytes_left = state_i.bytes_left - 8'd1;
                    res_o.byte_taken = 1'b1;
                    s = begin_wbyte(s, cfg_i);
                end
                PH_WB_BEGIN: begin
                    s = begin_wbyte(state_i, cfg_i);
                end
                PH_WB_BIT: begin
                    s.pins = drive_sda(state_i.pins, state_i.shift_byte[state_i.bit_index]);
                    s.tick_timer = gap16;
                    s.phase = PH_WB_HI;
                end
                PH_WB_HI: begin
                    s.pins = drive_scl(state_i.pins, 1'b1);
                    s.tick_timer = bit16;
                    s.phase = PH_WB_LO;
                end
                PH_WB_LO: begin
                    s.pins = drive_scl(state_i.pins, 1'b0);
                    s.tick_timer = gap16;
                    if (state_i.bit_index == 3'd0) begin
                        s.phase = PH_WB_END;
                    end else begin
                        s.bit_index = state_i.bit_index - 3'd1;
                        s.phase = PH_WB_BIT;
                    end
                end
                PH_WB_END: begin
                    s.pins = release_sda(state_i.pins);
                    s = start_wait(s, cfg_i, 1'b0);
                end
                PH_POLL_A, PH_POLL_R: begin
                    s.poll_count = poll_inc;
                    if (beat_i.scl_in || poll_inc >= cfg_i.stretch_polls) begin
                        s = finish_wait(s, cfg_i, state_i.phase == PH_POLL_R);
                    end else begin
                        s.tick_timer = bit16;
                    end
                end
                PH_CK: begin
                    res_o.ack_valid = 1'b1;
                    res_o.ack_low   = !beat_i.sda_in;
                    s.pins = drive_scl(state_i.pins, 1'b0);
                    s.tick_timer = gap16;
                    if (state_i.bytes_left == 8'd0) begin
                        s.phase = PH_STOP1;
                    end else begin
                        s.phase = state_i.is_read ? PH_RB_BEGIN : PH_WB_LOAD;
                    end
                end
                PH_RB_BEGIN: begin
                    s.pins       = release_sda(state_i.pins);
                    s.shift_byte = 8'd0;
                    s.bit_index  = TOP_BIT;
                    s.bytes_left = state_i.bytes_left - 8'd1;
                    s.tick_timer = bit16 + {7'd0, cfg_i.gap_ticks, 1'b0};
                    s.phase      = PH_RB_HI;
                end
                PH_RB_HI: begin
                    s.pins = drive_scl(state_i.pins, 1'b1);
                    s.tick_timer = gap16;
                    s.phase = PH_RB_SMP;
                end
                PH_RB_SMP: begin
                    s.shift_byte = smp_byte;
                    if (state_i.bit_index == 3'd0) begin
                        res_o.read_valid = 1'b1;
                        res_o.read_data  = smp_byte;
                    end
                    s.tick_timer = gap16;
                    s.phase = PH_RB_LO;
                end
                PH_RB_LO: begin
                    s.pins = drive_scl(state_i.pins, 1'b0);
                    if (state_i.bit_index == 3'd0) begin
                        s.tick_timer = gap16;
                        s.phase = PH_ACK_DRV;
                    end else begin
                        s.tick_timer = {7'd0, cfg_i.gap_ticks, 1'b0};
                        s.bit_index = state_i.bit_index - 3'd1;
                        s.phase = PH_RB_HI;
                    end
                end
                PH_ACK_DRV: begin
                    // ACK every byte but the last, which gets a NACK
                    s.pins = drive_sda(state_i.pins, state_i.bytes_left == 8'd0);
                    s.tick_timer = gap16;
                    s.phase = PH_ACK_HI;
                end
                PH_ACK_HI: begin
                    s.pins = drive_scl(state_i.pins, 1'b1);
                    s.tick_timer = bit16;
                    s.phase = PH_ACK_LO;
                end
                PH_ACK_LO: begin
                    s.pins = drive_scl(state_i.pins, 1'b0);
                    s.tick_timer = gap16;
                    s.phase = PH_REL_R;
                end
                PH_REL_R: begin
                    s = start_wait(state_i, cfg_i, 1'b1);
                end
                PH_STOP1: begin
                    s.pins = drive_sda(state_i.pins, 1'b0);
                    s.tick_timer = gap16;
                    s.phase = PH_STOP2;
                end
                PH_STOP2: begin
                    s.pins = drive_scl(state_i.pins, 1'b1);
                    s.tick_timer = bit16;
                    s.phase = PH_STOP3;
                end
                PH_STOP3: begin
                    s.pins = drive_sda(state_i.pins, 1'b1);
                    s.tick_timer = cfg_i.settle_ticks;
                    s.phase = PH_SETTLE;
                end
                PH_SETTLE: begin
                    res_o.done_res = 1'b1;
                    s.phase = PH_IDLE;
                end
                default: begin
                    s.phase      = PH_IDLE;
                    s.tick_timer = 16'd0;
                    s.pins       = PINS_HIGH;
                end
            endcase
        end

        res_o.pins     = s.pins;
        res_o.busy_res = (s.phase != PH_IDLE);
    end

    assign state_o = s;

endmodule
